// ===== hw/rtl/smx_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package smx_pkg;
  localparam int StackDepth = 64;
  localparam int PcBits = 16;
  localparam int AddrBits = $clog2(StackDepth);
  localparam int CntBits = $clog2(StackDepth + 1);

  typedef enum logic [4:0] {
    OP_LIT = 5'd0, OP_DUP = 5'd1, OP_DROP = 5'd2, OP_SWAP = 5'd3, OP_PICK = 5'd4,
    OP_ADD = 5'd5, OP_SUB = 5'd6, OP_MUL = 5'd7, OP_DIV = 5'd8, OP_MOD = 5'd9,
    OP_LESS = 5'd10, OP_CALL = 5'd11, OP_RET = 5'd12, OP_JUMP = 5'd13,
    OP_JUMPF = 5'd14, OP_PRINT = 5'd15, OP_HALT = 5'd16
  } op_e;

  typedef enum logic [2:0] {
    ERR_NONE = 3'd0, ERR_OVERFLOW = 3'd1, ERR_UNDERFLOW = 3'd2,
    ERR_DIV_ZERO = 3'd3, ERR_BAD_OP = 3'd4, ERR_PICK = 3'd5
  } err_e;

  typedef enum logic [2:0] {
    ST_IDLE, ST_READ, ST_EXEC, ST_WRITE2, ST_DIV, ST_OUT
  } state_e;
endpackage
`default_nettype wire

// ===== hw/rtl/smx_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface smx_in_if;
  logic              valid;
  logic              ready;
  logic [4:0]        func;
  logic signed [31:0] operand;
  logic [15:0]       pc;
  modport source (output valid, func, operand, pc, input ready);
  modport sink (input valid, func, operand, pc, output ready);
endinterface

interface smx_out_if;
  logic              valid;
  logic              ready;
  logic [15:0]       next_pc;
  logic              print_valid;
  logic signed [31:0] print_value;
  logic              halted;
  logic [2:0]        error;
  logic [6:0]        depth;
  modport source (output valid, next_pc, print_valid, print_value, halted, error, depth,
                  input ready);
  modport sink (input valid, next_pc, print_valid, print_value, halted, error, depth,
                output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/smx_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module smx_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]              rdata_o
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

// ===== hw/rtl/stack_machine_execute.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Channel | Dir | Fields
// req_i   | in  | func, operand, pc
// rsp_o   | out | next_pc, print_valid, print_value, halted, error, depth
//
// Stack words sit in two RAM copies so top and second are read together.
// A request passes through idle (accept, RAMs read top and second), read,
// execute and result. Pick repeats read for a second phase and swap adds a
// second write state; div/mod add a radix-2 divider (32 quotient bits, one write back).
// One request at a time; the result register holds while rsp_o is stalled.
// Reset clears only the depth and control; stack words are unset until pushed.
module stack_machine_execute (
  input wire logic clk_i,
  input wire logic rst_ni,
  smx_in_if.sink   req_i,
  smx_out_if.source rsp_o
);
  import smx_pkg::*;

  state_e state_q, state_d;
  logic [CntBits-1:0] cnt_q, cnt_d;
  logic [4:0]  func_q;
  logic [31:0] opnd_q;
  logic [15:0] pc_q;
  logic [31:0] a_q, b_q;
  logic        phase_q, phase_d;
  // ram ports
  logic we;
  logic [AddrBits-1:0] waddr, ra_a, ra_b;
  logic [31:0] wdata, rd_a, rd_b;
  // result
  logic [15:0] npc_q, npc_d;
  logic        pv_q, pv_d, hl_q, hl_d;
  logic [31:0] pval_q, pval_d;
  logic [2:0]  err_q, err_d;
  logic [31:0] w2_q, w2_d;
  logic [AddrBits-1:0] w2a_q, w2a_d;
  // divider
  logic [5:0]  dcnt_q, dcnt_d;
  logic [31:0] quo_q, quo_d, rem_q, rem_d, dvs_q, dvs_d;
  logic        qneg_q, qneg_d, rneg_q, rneg_d;

  smx_ram #(.Width(32), .Depth(StackDepth)) u_ram_a (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata), .raddr_i(ra_a), .rdata_o(rd_a));
  smx_ram #(.Width(32), .Depth(StackDepth)) u_ram_b (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata), .raddr_i(ra_b), .rdata_o(rd_b));

  logic [CntBits-1:0] n;
  logic [15:0] after2, target;
  logic [32:0] need;
  logic [32:0] trial;
  logic [31:0] na;
  assign n = cnt_q;
  assign after2 = pc_q + 16'd2;
  assign target = after2 + opnd_q[15:0];
  assign need = 33'd2 + {1'b0, opnd_q};
  assign trial = {rem_q, quo_q[31]} - {1'b0, dvs_q};

  assign req_i.ready = (state_q == ST_IDLE);
  assign rsp_o.valid = (state_q == ST_OUT);
  assign rsp_o.next_pc = npc_q;
  assign rsp_o.print_valid = pv_q;
  assign rsp_o.print_value = pval_q;
  assign rsp_o.halted = hl_q;
  assign rsp_o.error = err_q;
  assign rsp_o.depth = 7'(cnt_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q <= '0;
      phase_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      func_q <= req_i.func;
      opnd_q <= req_i.operand;
      pc_q <= req_i.pc;
    end
    if (state_q == ST_READ && !phase_q) begin
      a_q <= rd_a;
      b_q <= rd_b;
    end
    npc_q <= npc_d; pv_q <= pv_d; pval_q <= pval_d; hl_q <= hl_d; err_q <= err_d;
    w2_q <= w2_d; w2a_q <= w2a_d;
    dcnt_q <= dcnt_d; quo_q <= quo_d; rem_q <= rem_d; dvs_q <= dvs_d;
    qneg_q <= qneg_d; rneg_q <= rneg_d;
  end

  always_comb begin
    state_d = state_q; cnt_d = cnt_q; phase_d = phase_q;
    npc_d = npc_q; pv_d = pv_q; pval_d = pval_q; hl_d = hl_q; err_d = err_q;
    w2_d = w2_q; w2a_d = w2a_q;
    dcnt_d = dcnt_q; quo_d = quo_q; rem_d = rem_q; dvs_d = dvs_q;
    qneg_d = qneg_q; rneg_d = rneg_q;
    we = 1'b0; waddr = '0; wdata = '0;
    ra_a = AddrBits'(cnt_q - 1'b1);
    ra_b = AddrBits'(cnt_q - 2'd2);
    na = '0;
    unique case (state_q)
      ST_IDLE: begin
        phase_d = 1'b0;
        if (req_i.valid) state_d = ST_READ;
      end
      ST_READ: begin
        // phase 0: top and second arrive; pick address held through phase 1
        // so the picked entry sits on rd_a during execute
        if (func_q == OP_PICK) ra_a = AddrBits'(n - 1'b1 - opnd_q[CntBits-1:0]);
        if (func_q == OP_PICK && !phase_q) begin
          phase_d = 1'b1;
        end else begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        npc_d = pc_q + 16'd1; pv_d = 1'b0; pval_d = '0; hl_d = 1'b0; err_d = ERR_NONE;
        state_d = ST_OUT;
        unique case (func_q)
          OP_LIT: begin
            if (n >= CntBits'(StackDepth)) err_d = ERR_OVERFLOW;
            else begin
              we = 1'b1; waddr = AddrBits'(n); wdata = opnd_q;
              cnt_d = n + 1'b1; npc_d = after2;
            end
          end
          OP_DUP: begin
            if (n < 1) err_d = ERR_UNDERFLOW;
            else if (n >= CntBits'(StackDepth)) err_d = ERR_OVERFLOW;
            else begin
              we = 1'b1; waddr = AddrBits'(n); wdata = a_q; cnt_d = n + 1'b1;
            end
          end
          OP_DROP: begin
            if (n < 1) err_d = ERR_UNDERFLOW;
            else cnt_d = n - 1'b1;
          end
          OP_SWAP: begin
            if (n < 2) err_d = ERR_UNDERFLOW;
            else begin
              we = 1'b1; waddr = AddrBits'(n - 1'b1); wdata = b_q;
              w2_d = a_q; w2a_d = AddrBits'(n - 2'd2); state_d = ST_WRITE2;
            end
          end
          OP_PICK: begin
            if (opnd_q[31] || opnd_q >= 32'(n)) err_d = ERR_PICK;
            else if (n >= CntBits'(StackDepth)) err_d = ERR_OVERFLOW;
            else begin
              we = 1'b1; waddr = AddrBits'(n); wdata = rd_a;
              cnt_d = n + 1'b1; npc_d = after2;
            end
          end
          OP_ADD, OP_SUB, OP_MUL, OP_LESS, OP_DIV, OP_MOD: begin
            if (n < 2) err_d = ERR_UNDERFLOW;
            else if ((func_q == OP_DIV || func_q == OP_MOD) && a_q == '0) err_d = ERR_DIV_ZERO;
            else if (func_q == OP_DIV || func_q == OP_MOD) begin
              qneg_d = a_q[31] ^ b_q[31]; rneg_d = b_q[31];
              quo_d = b_q[31] ? -b_q : b_q;
              dvs_d = a_q[31] ? -a_q : a_q;
              rem_d = '0; dcnt_d = 6'd32; state_d = ST_DIV;
            end else begin
              unique case (func_q)
                OP_ADD: na = b_q + a_q;
                OP_SUB: na = b_q - a_q;
                OP_MUL: na = b_q * a_q;
                default: na = {31'd0, $signed(b_q) < $signed(a_q)};
              endcase
              we = 1'b1; waddr = AddrBits'(n - 2'd2); wdata = na; cnt_d = n - 1'b1;
            end
          end
          OP_CALL: begin
            if (n >= CntBits'(StackDepth)) err_d = ERR_OVERFLOW;
            else begin
              we = 1'b1; waddr = AddrBits'(n); wdata = 32'(after2);
              cnt_d = n + 1'b1; npc_d = target;
            end
          end
          OP_RET: begin
            if ({26'd0, n} < need) err_d = ERR_UNDERFLOW;
            else begin
              we = 1'b1; waddr = AddrBits'(33'(n) - need); wdata = a_q;
              cnt_d = CntBits'(33'(n) - need + 33'd1); npc_d = b_q[15:0];
            end
          end
          OP_JUMP: npc_d = target;
          OP_JUMPF: begin
            if (n < 1) err_d = ERR_UNDERFLOW;
            else begin
              cnt_d = n - 1'b1; npc_d = (a_q == '0) ? target : after2;
            end
          end
          OP_PRINT: begin
            if (n < 1) err_d = ERR_UNDERFLOW;
            else begin
              cnt_d = n - 1'b1; pv_d = 1'b1; pval_d = a_q;
            end
          end
          OP_HALT: begin
            hl_d = 1'b1; npc_d = pc_q;
          end
          default: err_d = ERR_BAD_OP;
        endcase
        if (err_d != ERR_NONE) npc_d = pc_q;
      end
      ST_WRITE2: begin
        we = 1'b1; waddr = w2a_q; wdata = w2_q; state_d = ST_OUT;
      end
      ST_DIV: begin
        // restoring division, one quotient bit per cycle
        if (dcnt_q != '0) begin
          if (!trial[32]) rem_d = trial[31:0];
          else rem_d = {rem_q[30:0], quo_q[31]};
          quo_d = {quo_q[30:0], ~trial[32]};
          dcnt_d = dcnt_q - 1'b1;
        end else begin
          na = (func_q == OP_DIV) ? (qneg_q ? -quo_q : quo_q) : (rneg_q ? -rem_q : rem_q);
          we = 1'b1; waddr = AddrBits'(n - 2'd2); wdata = na; cnt_d = n - 1'b1;
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (rsp_o.ready) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire
